FILE: sv/dhc_pkg.sv
// Package for the deck heat conduction step block: field widths, codes,
// cell control struct and the temperature saturation helper.
// No dependencies.
package dhc_pkg;

  localparam int TEMP_W     = 17;
  localparam int IDX_W      = 5;
  localparam int INV_W      = 16;
  localparam int SOK_W      = 24;
  localparam int H_W        = 18;
  localparam int FLUX_W     = 21;
  localparam int ERR_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // Widths of the internal fixed point terms.
  localparam int HS_W   = H_W + SOK_W;      // h * spacing_over_k, Q.32
  localparam int HALF_W = HS_W / 2;         // split point of hs for the multiplies
  localparam int CONV_W = 43;               // convection term, Q.24
  localparam int FX_W   = 42;               // flux term, signed Q.24
  localparam int C_W    = 33;               // 1 - 2N, Q.32
  localparam int A_W    = 46;               // boundary bracket, signed Q.24
  localparam int A_LO_W = 23;

  localparam logic [INV_W-1:0]  INV_M_RESET = 16'd8192;
  localparam logic [SOK_W-1:0]  SOK_RESET   = 24'd117440;
  localparam logic [15:0]       N_CLAMP     = 16'd32702;
  localparam logic signed [32:0] RATE_LIMIT = 33'sd2048;
  localparam logic signed [31:0] LOW_LIMIT  = 32'sd51200;
  localparam logic signed [31:0] TEMP_MAX_S = 32'sd131071;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } dhc_mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK   = 2'd0,
    ERR_ZERO = 2'd1,
    ERR_RATE = 2'd2,
    ERR_LOW  = 2'd3
  } dhc_err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_M   = 1'b0,
    REG_SPACING = 1'b1
  } dhc_reg_t;

  typedef struct packed {
    logic wr;      // write wr_data into the node
    logic commit;  // take the updated value
  } dhc_cell_ctrl_t;

  function automatic logic [TEMP_W-1:0] sat_temp(input logic signed [31:0] v);
    logic [TEMP_W-1:0] r;
    if (v < 32'sd0) begin
      r = '0;
    end else if (v > TEMP_MAX_S) begin
      r = '1;
    end else begin
      r = v[TEMP_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/dhc_if.sv
// Handshake interfaces of the deck heat conduction step block: input items,
// result items and configuration writes. Depends on dhc_pkg.
interface dhc_item_if import dhc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [IDX_W-1:0]         node_index;
  logic [TEMP_W-1:0]        load_temp;
  logic [TEMP_W-1:0]        surface_temp;
  logic [TEMP_W-1:0]        air_temp;
  logic [H_W-1:0]           conv_coeff;
  logic signed [FLUX_W-1:0] radiation_flux;
  logic signed [FLUX_W-1:0] latent_flux;

  modport source (output valid, mode, node_index, load_temp, surface_temp, air_temp,
                  conv_coeff, radiation_flux, latent_flux, input ready);
  modport sink (input valid, mode, node_index, load_temp, surface_temp, air_temp,
                conv_coeff, radiation_flux, latent_flux, output ready);
endinterface

interface dhc_result_if import dhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] new_surface_temp;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, new_surface_temp, error_code, input ready);
  modport sink (input valid, new_surface_temp, error_code, output ready);
endinterface

interface dhc_cfg_if import dhc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/deck_heat_conduction_step.sv
// Deck heat conduction step: a row of node cells updated by an explicit
// finite-difference step. A load item goes from acceptance to the emit state,
// a step item first through the pipe states, sized by the coefficient pipeline
// and the split boundary multiplies, then commit and check; emit registers results.
// Reset (rst, synchronous) sets the control state and the configuration
// registers; node temperatures are not cleared and hold garbage until loaded.
module deck_heat_conduction_step import dhc_pkg::*; #(
  parameter int NUM_NODES = 20
) (
  input  logic          clk,
  input  logic          rst,
  dhc_item_if.sink      item,
  dhc_result_if.source  result,
  dhc_cfg_if.sink       cfg
);

  // The sequencer walks a step through the coefficient pipeline. Every
  // pipeline register runs free over held operands, so the states only
  // count the pipeline depth until the commit edge.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PIPE1,
    S_PIPE2,
    S_PIPE3,
    S_PIPE4,
    S_PIPE5,
    S_COMMIT,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [INV_W-1:0] inv_m;
  logic [SOK_W-1:0] spacing_over_k;

  // Operands of the current step, held for the whole item.
  logic [TEMP_W-1:0]      sfc;
  logic [TEMP_W-1:0]      ta;
  logic [H_W-1:0]         h;
  logic signed [FLUX_W:0] fsum;

  // Pending and delivered result.
  logic [TEMP_W-1:0] pend_temp;
  dhc_err_t          pend_err;
  logic              res_valid;
  logic [TEMP_W-1:0] res_temp;
  dhc_err_t          res_err;
  logic signed [31:0] new0;

  logic                   item_acc;
  logic                   slot_free;
  logic [C_W-1:0]         c;
  logic [CONV_W-1:0]      conv;
  logic signed [FX_W-1:0] flux;
  logic signed [31:0]     rnd_top;
  logic signed [31:0]     rnd_bot;
  logic signed [32:0]     diff;
  logic signed [32:0]     diff_abs;

  logic [TEMP_W-1:0] temps   [NUM_NODES];
  dhc_cell_ctrl_t    ctrl    [NUM_NODES];
  logic [TEMP_W-1:0] seed;

  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  // The output register parts the two sides: a finished result waits there
  // while the block already takes the next item.
  assign slot_free        = !res_valid || result.ready;
  assign result.valid     = res_valid;
  assign result.new_surface_temp = res_temp;
  assign result.error_code       = res_err;

  // A step seeds the surface node with the given surface temperature; a load
  // writes the addressed node. An index past the last node matches no cell.
  assign seed = (item.mode == MODE_STEP) ? item.surface_temp : item.load_temp;

  always_comb begin
    for (int i = 0; i < NUM_NODES; i++) begin
      ctrl[i].wr = item_acc && (((item.mode == MODE_LOAD) && (int'(item.node_index) == i))
                   || ((i == 0) && (item.mode == MODE_STEP)));
      ctrl[i].commit = (state == S_COMMIT);
    end
  end

  // Rate check against the surface temperature and the cold surface check,
  // both on the rounded surface value before saturation.
  assign diff     = $signed(33'(new0)) - $signed({16'b0, sfc});
  assign diff_abs = diff[32] ? -diff : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_m          <= INV_M_RESET;
      spacing_over_k <= SOK_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INV_M:   inv_m <= cfg.data[INV_W-1:0];
        REG_SPACING: spacing_over_k <= cfg.data[SOK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // A new result takes the slot in the same cycle the old one leaves.
      if ((state == S_EMIT) && slot_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (item.mode == MODE_STEP) begin
              sfc   <= item.surface_temp;
              ta    <= item.air_temp;
              h     <= item.conv_coeff;
              fsum  <= (FLUX_W+1)'(item.radiation_flux) + (FLUX_W+1)'(item.latent_flux);
              state <= S_PIPE1;
            end else begin
              // A load reports the surface node as it stands after the write.
              pend_temp <= (item.node_index == '0) ? item.load_temp : temps[0];
              pend_err  <= (item.load_temp == '0) ? ERR_ZERO : ERR_OK;
              state     <= S_EMIT;
            end
          end
        end
        S_PIPE1:  state <= S_PIPE2;
        S_PIPE2:  state <= S_PIPE3;
        S_PIPE3:  state <= S_PIPE4;
        S_PIPE4:  state <= S_PIPE5;
        S_PIPE5:  state <= S_COMMIT;
        S_COMMIT: begin
          new0  <= rnd_top;
          state <= S_CHECK;
        end
        S_CHECK: begin
          pend_temp <= temps[0];
          if (diff_abs > RATE_LIMIT) begin
            pend_err <= ERR_RATE;
          end else if (new0 < LOW_LIMIT) begin
            pend_err <= ERR_LOW;
          end else begin
            pend_err <= ERR_OK;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            res_temp  <= pend_temp;
            res_err   <= pend_err;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dhc_coef u_coef (
    .clk            (clk),
    .inv_m          (inv_m),
    .spacing_over_k (spacing_over_k),
    .conv_coeff     (h),
    .air_temp       (ta),
    .flux_sum       (fsum),
    .c              (c),
    .conv           (conv),
    .flux           (flux)
  );

  // Surface node: convection, radiative and latent flux, conduction from node 1.
  dhc_edge u_top (
    .clk     (clk),
    .ctrl    (ctrl[0]),
    .wr_data (seed),
    .nb      (temps[1]),
    .inv_m   (inv_m),
    .c       (c),
    .conv    (conv),
    .flux    (flux),
    .temp    (temps[0]),
    .rounded (rnd_top)
  );

  // Interior nodes, each fed by its two neighbors every cycle.
  for (genvar i = 1; i < NUM_NODES - 1; i++) begin : g_cell
    dhc_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl[i]),
      .wr_data (item.load_temp),
      .left    (temps[i-1]),
      .right   (temps[i+1]),
      .inv_m   (inv_m),
      .temp    (temps[i])
    );
  end

  // Underside node: convection and conduction, no flux.
  dhc_edge u_bot (
    .clk     (clk),
    .ctrl    (ctrl[NUM_NODES-1]),
    .wr_data (item.load_temp),
    .nb      (temps[NUM_NODES-2]),
    .inv_m   (inv_m),
    .c       (c),
    .conv    (conv),
    .flux    ('0),
    .temp    (temps[NUM_NODES-1]),
    .rounded (rnd_bot)
  );

  // A step item seeds the surface node before the update starts.
  a_seed: assert property (@(posedge clk) disable iff (rst)
    item_acc && (item.mode == MODE_STEP) |=> temps[0] == $past(item.surface_temp))
    else $error("surface node not seeded by step item");

  // A load of node zero lands in the surface cell at once.
  a_load0: assert property (@(posedge clk) disable iff (rst)
    item_acc && (item.mode == MODE_LOAD) && (item.node_index == '0)
    |=> temps[0] == $past(item.load_temp))
    else $error("load of surface node lost");

  // The committed surface node is the saturated form of the checked value.
  a_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> temps[0] == sat_temp(new0))
    else $error("surface commit disagrees with rounded value");

  // The underside value is only committed, never reported; it must still be
  // the saturated form of its own rounded sum.
  a_commit_bot: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |=> temps[NUM_NODES-1] == sat_temp($past(rnd_bot)))
    else $error("underside commit disagrees with rounded value");

endmodule

FILE: sv/dhc_coef.sv
// Coefficient pipeline shared by the two boundary cells: hs, 1 - 2N, the
// convection term and the flux term. Depends on dhc_pkg.
module dhc_coef import dhc_pkg::*; (
  input  logic                     clk,
  input  logic [INV_W-1:0]         inv_m,
  input  logic [SOK_W-1:0]         spacing_over_k,
  input  logic [H_W-1:0]           conv_coeff,
  input  logic [TEMP_W-1:0]        air_temp,
  input  logic signed [FLUX_W:0]   flux_sum,
  output logic [C_W-1:0]           c,
  output logic [CONV_W-1:0]        conv,
  output logic signed [FX_W-1:0]   flux
);

  localparam int NP_W = HALF_W + INV_W;
  localparam int CP_W = HALF_W + TEMP_W;
  localparam int FP_W = FLUX_W + 1 + SOK_W + 1;

  logic [HS_W-1:0]        hs;
  logic signed [FP_W-1:0] fp;
  logic [NP_W-1:0]        n_lo, n_hi;
  logic [CP_W-1:0]        c_lo, c_hi;
  logic                   n_big;
  logic [31:0]            nq32;
  logic [58:0]            nq48_sum;
  logic [58:0]            conv_sum;
  logic signed [FP_W-1:0] fp_adj;

  // N in Q.48 and hs * Ta rebuilt from the split partial products.
  assign nq48_sum = (59'(inv_m) << 32) + (59'(n_hi) << HALF_W) + 59'(n_lo);
  assign conv_sum = (59'(c_hi) << HALF_W) + 59'(c_lo);
  // Division by 16 truncates toward zero.
  assign fp_adj   = fp + (fp[FP_W-1] ? FP_W'(15) : FP_W'(0));

  always_ff @(posedge clk) begin
    hs    <= conv_coeff * spacing_over_k;
    fp    <= flux_sum * $signed({1'b0, spacing_over_k});
    n_lo  <= hs[HALF_W-1:0] * inv_m;
    n_hi  <= hs[HS_W-1:HALF_W] * inv_m;
    c_lo  <= hs[HALF_W-1:0] * air_temp;
    c_hi  <= hs[HS_W-1:HALF_W] * air_temp;
    n_big <= nq48_sum > (59'(1) << 47);
    nq32  <= nq48_sum[47:16];
    conv  <= conv_sum[58:16];
    flux  <= fp_adj[FX_W+3:4];
    c     <= {1'b1, 32'b0} - (n_big ? {N_CLAMP, 17'b0} : {nq32, 1'b0});
  end

endmodule

FILE: sv/dhc_cell.sv
// Interior node cell: holds one node temperature and updates it from its
// two neighbors by pure conduction. Depends on dhc_pkg.
module dhc_cell import dhc_pkg::*; (
  input  logic              clk,
  input  dhc_cell_ctrl_t    ctrl,
  input  logic [TEMP_W-1:0] wr_data,
  input  logic [TEMP_W-1:0] left,
  input  logic [TEMP_W-1:0] right,
  input  logic [INV_W-1:0]  inv_m,
  output logic [TEMP_W-1:0] temp
);

  logic [TEMP_W:0]          nb_sum;
  logic signed [17:0]       k;
  logic [INV_W+TEMP_W:0]    pm;
  logic signed [34:0]       pk;
  logic signed [36:0]       s;
  logic signed [20:0]       rnd;

  assign nb_sum = (TEMP_W+1)'(left) + (TEMP_W+1)'(right);
  // Center weight 1 - 2I, Q.16; negative when inv_m is above one half.
  assign k      = 18'sd65536 - $signed({1'b0, inv_m, 1'b0});
  assign s      = $signed(37'(pm)) + 37'(pk) + 37'sd32768;
  assign rnd    = s[36:16];

  always_ff @(posedge clk) begin
    pm <= inv_m * nb_sum;
    pk <= k * $signed({1'b0, temp});
    if (ctrl.wr) begin
      temp <= wr_data;
    end else if (ctrl.commit) begin
      temp <= sat_temp(32'(rnd));
    end
  end

endmodule

FILE: sv/dhc_edge.sv
// Boundary node cell for the surface and the underside: convection, flux and
// conduction from the one neighbor, with split multiplies. Depends on dhc_pkg.
module dhc_edge import dhc_pkg::*; (
  input  logic                   clk,
  input  dhc_cell_ctrl_t         ctrl,
  input  logic [TEMP_W-1:0]      wr_data,
  input  logic [TEMP_W-1:0]      nb,
  input  logic [INV_W-1:0]       inv_m,
  input  logic [C_W-1:0]         c,
  input  logic [CONV_W-1:0]      conv,
  input  logic signed [FX_W-1:0] flux,
  output logic [TEMP_W-1:0]      temp,
  output logic signed [31:0]     rounded
);

  logic [INV_W:0]            two_i;
  logic signed [A_W-1:0]     a;
  logic [INV_W+A_LO_W:0]     pa_lo;
  logic signed [40:0]        pa_hi;
  logic [C_W+TEMP_W-1:0]     pc;
  logic signed [63:0]        sum;

  assign two_i = {inv_m, 1'b0};
  // Round half up: add one half, then keep the upper word.
  assign sum = (64'(pa_hi) <<< A_LO_W) + $signed(64'(pa_lo)) + $signed(64'(pc))
             + 64'sd2147483648;
  assign rounded = sum[63:32];

  always_ff @(posedge clk) begin
    a     <= $signed(A_W'(conv)) + A_W'(flux) + $signed(A_W'({nb, 16'b0}));
    pa_lo <= two_i * a[A_LO_W-1:0];
    pa_hi <= $signed({1'b0, two_i}) * $signed(a[A_W-1:A_LO_W]);
    pc    <= c * temp;
    if (ctrl.wr) begin
      temp <= wr_data;
    end else if (ctrl.commit) begin
      temp <= sat_temp(rounded);
    end
  end

endmodule

FILE: tb/slab_check_pkg.sv
// Item and result types for the deck heat conduction step testbench, and a
// scoreboard class that predicts every result and checks what the block sends.
// Depends on dhc_pkg.
package slab_check_pkg;
  import dhc_pkg::*;

  localparam int     NODES            = 20;
  localparam longint INV_M_AT_RESET   = 8192;
  localparam longint SPACING_AT_RESET = 117440;
  localparam longint RATE_STEP_MAX    = 2048;       // 8 K in Q9.8
  localparam longint COLD_FLOOR       = 51200;      // 200 K in Q9.8
  localparam longint N_CAP_Q16        = 32702;      // 0.499 in Q.16
  localparam longint TEMP_TOP         = 131071;
  localparam longint ONE_Q16          = 64'sd65536;
  localparam longint ONE_Q32          = 64'sd4294967296;
  localparam longint HALF_Q48         = 64'sd140737488355328;

  typedef struct {
    dhc_mode_t                mode;
    logic [IDX_W-1:0]         node_index;
    logic [TEMP_W-1:0]        load_temp;
    logic [TEMP_W-1:0]        surface_temp;
    logic [TEMP_W-1:0]        air_temp;
    logic [H_W-1:0]           conv_coeff;
    logic signed [FLUX_W-1:0] radiation_flux;
    logic signed [FLUX_W-1:0] latent_flux;
  } slab_item_t;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    dhc_err_t          code;
  } surface_result_t;

  class slab_scoreboard;
    longint          inv_m;
    longint          spacing;
    longint          node_k[NODES];
    surface_result_t expected_surface[$];
    int              failures;
    int              checked;

    function new();
      inv_m    = INV_M_AT_RESET;
      spacing  = SPACING_AT_RESET;
      foreach (node_k[n]) node_k[n] = 0;
      failures = 0;
      checked  = 0;
    endfunction

    // Round half up at bit sh: a floor of the biased value.
    static function longint round_q(longint s, int sh);
      return (s + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    static function logic [TEMP_W-1:0] clip_temp(longint v);
      if (v < 0) return '0;
      if (v > TEMP_TOP) return '1;
      return TEMP_W'(v);
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", what);
    endfunction

    function void set_register(dhc_reg_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_INV_M) inv_m = longint'(value[INV_W-1:0]);
      else spacing = longint'(value);
    endfunction

    // Apply one accepted item to the predicted slab and queue its result.
    function void note_item(slab_item_t it);
      longint          prev[NODES];
      longint          hs, n48, n32, c_w, conv, flux, two_i, k_w, new0, diff;
      surface_result_t want;
      if (it.mode == MODE_LOAD) begin
        if (it.node_index < NODES) node_k[it.node_index] = longint'(it.load_temp);
        want.temp = TEMP_W'(node_k[0]);
        want.code = (it.load_temp == '0) ? ERR_ZERO : ERR_OK;
      end else begin
        node_k[0] = longint'(it.surface_temp);
        prev = node_k;
        hs   = longint'(it.conv_coeff) * spacing;
        n48  = (ONE_Q32 + hs) * inv_m;
        n32  = (n48 > HALF_Q48) ? (N_CAP_Q16 << 16) : (n48 >>> 16);
        c_w  = ONE_Q32 - 2 * n32;
        conv = (hs * longint'(it.air_temp)) >>> 16;
        flux = (longint'(it.radiation_flux) + longint'(it.latent_flux)) * spacing / 16;
        two_i = 2 * inv_m;
        k_w   = ONE_Q16 - two_i;
        new0 = round_q(two_i * (conv + flux + prev[1] * ONE_Q16) + c_w * prev[0], 32);
        node_k[0] = clip_temp(new0);
        for (int n = 1; n < NODES - 1; n++) begin
          node_k[n] = clip_temp(round_q(inv_m * (prev[n-1] + prev[n+1]) + k_w * prev[n], 16));
        end
        node_k[NODES-1] = clip_temp(round_q(two_i * (conv + prev[NODES-2] * ONE_Q16)
                                            + c_w * prev[NODES-1], 32));
        diff = new0 - longint'(it.surface_temp);
        if (diff < 0) diff = -diff;
        want.temp = TEMP_W'(node_k[0]);
        if (diff > RATE_STEP_MAX) want.code = ERR_RATE;
        else if (new0 < COLD_FLOOR) want.code = ERR_LOW;
        else want.code = ERR_OK;
      end
      expected_surface.push_back(want);
    endfunction

    function void check_surface(logic [TEMP_W-1:0] temp, logic [ERR_W-1:0] code);
      surface_result_t want;
      checked++;
      if (expected_surface.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing expected: temp %0d code %0d",
                       checked, temp, code));
        return;
      end
      want = expected_surface.pop_front();
      if (temp !== want.temp || code !== want.code) begin
        flag($sformatf("result %0d: temp %0d code %0d, expected temp %0d code %0d",
                       checked, temp, code, want.temp, want.code));
      end
    endfunction

    function void close_out();
      if (expected_surface.size() != 0) begin
        flag($sformatf("%0d expected results never arrived", expected_surface.size()));
      end
    endfunction
  endclass

endpackage

FILE: tb/deck_heat_conduction_step_test.sv
// Top-level testbench for deck_heat_conduction_step: drives load, step and
// register items with random idling and checks every result against a
// predictor. Depends on dhc_pkg, dhc_if and slab_check_pkg.
module deck_heat_conduction_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dhc_pkg::*;
  import slab_check_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;
  // Far beyond the slowest legal run: every item waiting out the longest
  // sender gap, the step latency and the longest receiver stall.
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst = 1'b1;

  dhc_item_if   item_if();
  dhc_result_if result_if();
  dhc_cfg_if    cfg_if();

  deck_heat_conduction_step #(.NUM_NODES(NODES)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  slab_scoreboard board;
  slab_item_t     taken;
  bit             no_idle;       // set for phases that run with no gaps at all
  int             sent;          // items handed to the driver so far
  int             items_taken;
  int             steps_taken;
  int             cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The run ends here if the block stops answering.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Monitor. Results are checked before the item of the same edge is noted;
  // a result can never belong to an item accepted at the same edge, so the
  // order only keeps things easy to follow.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        board.check_surface(result_if.new_surface_temp, result_if.error_code);
      end
      if (item_if.valid && item_if.ready) begin
        taken.mode           = dhc_mode_t'(item_if.mode);
        taken.node_index     = item_if.node_index;
        taken.load_temp      = item_if.load_temp;
        taken.surface_temp   = item_if.surface_temp;
        taken.air_temp       = item_if.air_temp;
        taken.conv_coeff     = item_if.conv_coeff;
        taken.radiation_flux = item_if.radiation_flux;
        taken.latent_flux    = item_if.latent_flux;
        board.note_item(taken);
        items_taken++;
        if (taken.mode == MODE_STEP) steps_taken++;
      end
    end
  end

  // Result side: before each result it holds ready low for a random number
  // of cycles, except in the gap-free phases.
  initial begin
    int hold;
    result_if.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        result_if.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      result_if.ready = 1'b1;
      do @(posedge clk); while (!result_if.valid);
      @(negedge clk);
    end
  end

  // Every field random over what its width allows; air temperature stays in
  // its physical range. Roughly one load in eight carries a zero value.
  function automatic slab_item_t noise_item();
    slab_item_t it;
    it.mode           = dhc_mode_t'($urandom_range(0, 1));
    it.node_index     = IDX_W'($urandom_range(0, 31));
    it.load_temp      = ($urandom_range(0, 7) == 0) ? '0 : TEMP_W'($urandom());
    it.surface_temp   = TEMP_W'($urandom());
    it.air_temp       = TEMP_W'($urandom_range(51200, 104960));
    it.conv_coeff     = H_W'($urandom());
    it.radiation_flux = FLUX_W'($urandom());
    it.latent_flux    = FLUX_W'($urandom());
    return it;
  endfunction

  // The fields a load ignores are left random on purpose.
  function automatic slab_item_t make_load(int idx, int temp);
    slab_item_t it;
    it            = noise_item();
    it.mode       = MODE_LOAD;
    it.node_index = IDX_W'(idx);
    it.load_temp  = TEMP_W'(temp);
    return it;
  endfunction

  function automatic slab_item_t make_step(int sfc, int air, int h, int rad, int lat);
    slab_item_t it;
    it                = noise_item();
    it.mode           = MODE_STEP;
    it.surface_temp   = TEMP_W'(sfc);
    it.air_temp       = TEMP_W'(air);
    it.conv_coeff     = H_W'(h);
    it.radiation_flux = FLUX_W'(rad);
    it.latent_flux    = FLUX_W'(lat);
    return it;
  endfunction

  // Starts and ends on a falling edge. Valid stays high from one item to the
  // next when no gap is drawn.
  task automatic send(input slab_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.mode           = it.mode;
    item_if.node_index     = it.node_index;
    item_if.load_temp      = it.load_temp;
    item_if.surface_temp   = it.surface_temp;
    item_if.air_temp       = it.air_temp;
    item_if.conv_coeff     = it.conv_coeff;
    item_if.radiation_flux = it.radiation_flux;
    item_if.latent_flux    = it.latent_flux;
    item_if.valid          = 1'b1;
    sent++;
    do @(posedge clk); while (!item_if.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input dhc_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.index = idx;
    cfg_if.data  = value;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_register(idx, value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Every item gives exactly one result, so an empty queue means the block
  // is idle.
  task automatic wait_drained();
    while (board.expected_surface.size() != 0) @(posedge clk);
  endtask

  // A well-formed sequence: a fresh, smooth temperature profile through the
  // whole slab, then a run of steps with plausible weather. Now and then the
  // surface drops below 200 K or jumps anywhere, and a node is zeroed.
  task automatic run_slab_profile();
    int base, sfc, h, count;
    base = $urandom_range(66560, 81920);
    for (int n = 0; n < NODES; n++) begin
      if ($urandom_range(0, 19) == 0) send(make_load(n, 0));
      else send(make_load(n, base + $urandom_range(0, 1024) - 512));
    end
    count = $urandom_range(3, 15);
    repeat (count) begin
      sfc = base + $urandom_range(0, 2048) - 1024;
      case ($urandom_range(0, 7))
        0: sfc = $urandom_range(40960, 51200);
        1: sfc = $urandom_range(0, 131071);
        default: ;
      endcase
      h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 15360);
      send(make_step(sfc, $urandom_range(61440, 81920), h,
                     $urandom_range(0, 17600) - 3200, $urandom_range(0, 6400) - 4800));
    end
  endtask

  initial begin
    int               phase_end;
    logic [INV_W-1:0] inv_pick;
    logic [SOK_W-1:0] sok_pick;

    board = new();
    cycles = 0;
    sent = 0;
    items_taken = 0;
    steps_taken = 0;
    no_idle = 1'b0;
    item_if.valid          = 1'b0;
    item_if.mode           = MODE_LOAD;
    item_if.node_index     = '0;
    item_if.load_temp      = '0;
    item_if.surface_temp   = '0;
    item_if.air_temp       = '0;
    item_if.conv_coeff     = '0;
    item_if.radiation_flux = '0;
    item_if.latent_flux    = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_INV_M;
    cfg_if.data  = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, under the reset coefficients. The node memory holds
    // garbage after reset and a load reports node 0, so node 0 is written
    // first and the whole slab is filled before the first step.
    send(make_load(0, 131071));
    for (int n = 1; n < NODES; n++) begin
      send(make_load(n, (n == 10) ? 1 : 70000 + n * 100));
    end
    // A zero value at an index past the slab: nothing stored, zero flagged.
    send(make_load(31, 0));
    // A zero value inside the slab is stored and flagged.
    send(make_load(7, 0));
    // Every step field at an extreme, both ways; the surface saturates.
    send(make_step(0, 104960, 262143, 1048575, 1048575));
    send(make_step(131071, 51200, 0, -1048576, -1048576));
    send(make_step(70000, 70000, 2560, 0, 0));

    // Random part, one coefficient setting per phase: the reset values, both
    // ends of each register, the exact N = 0.5 boundary, unstable interior
    // weights above 0.5, then random settings. Two phases run with no idling.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin inv_pick = 16'd8192;  sok_pick = 24'd117440;   end
        1: begin inv_pick = 16'd0;     sok_pick = 24'd1;        end
        2: begin inv_pick = 16'd32768; sok_pick = 24'hFFFFFF;   end
        3: begin inv_pick = 16'd32768; sok_pick = 24'd117440;   end
        4: begin inv_pick = 16'd1;     sok_pick = 24'hFFFFFF;   end
        5: begin inv_pick = 16'd40000; sok_pick = 24'd117440;   end
        6: begin inv_pick = 16'hFFFF;  sok_pick = 24'd1;        end
        default: begin
          inv_pick = INV_W'($urandom_range(0, 32768));
          sok_pick = SOK_W'($urandom_range(1, 24'hFFFFFF));
        end
      endcase
      // Registers change only with the block idle.
      item_if.valid = 1'b0;
      wait_drained();
      no_idle = (p == 2 || p == 7);
      write_reg(REG_INV_M, {{(CFG_DATA_W-INV_W){1'b0}}, inv_pick});
      write_reg(REG_SPACING, sok_pick);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) run_slab_profile();
        else repeat ($urandom_range(1, 5)) send(noise_item());
      end
    end

    item_if.valid = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    board.close_out();

    $display("Checked %0d results for %0d items (%0d steps, %0d loads)",
             board.checked, items_taken, steps_taken, items_taken - steps_taken);
    $display("over %0d coefficient settings, %0d failures", PHASES + 1, board.failures);
    if (board.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
